// ----- design/imudr_pkg.sv -----
// ----------------------------------------------------------------------------
// imudr_pkg: shared types and helpers for the IMU odometry block
// Beat types for both channels, register codes and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package imudr_pkg;

    localparam int SINE_TABLE_BITS_DEFAULT = 10;
    localparam logic [14:0] THRESHOLD_RESET = 15'd512;
    localparam logic [31:0] TIMEOUT_RESET   = 32'd65536;
    localparam logic signed [32:0] INV_TWO_PI_Q32 = 33'sd683565276;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Register indexes on the configuration port.
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    typedef struct packed {
        logic [31:0]        sample_time;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] yaw_rate;
    } imu_sample_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [15:0] turn_rate;
        logic               stationary;
    } odom_result_t;

    // One quarter-wave entry, round(32768*sin(pi/2*i/2^bits)), from a series.
    function automatic logic [16:0] sine_entry(input int bits, input int i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        x = (PI_HALF_Q30 * 64'(i)) >> bits;
        x2 = (x * x) >> 30;
        term = x;
        sum = $signed(x);
        for (int k = 1; k <= 10; k++)
        begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32768)
            sum = 64'sd32768;
        return sum[16:0];
    endfunction

    // Adds a wide delta to a 32-bit value and clamps to the signed range.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [68:0] d);
        logic signed [69:0] s;
        s = 70'(a) + 70'(d);
        if (s > 70'sd2147483647)
            return 32'sh7fffffff;
        else if (s < -70'sd2147483648)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/imu_dead_reckoning_odometry.sv -----
// ----------------------------------------------------------------------------
// imu_dead_reckoning_odometry: IMU dead reckoning with zero-velocity update
// Integrates position, heading and velocity from timestamped IMU samples.
// ----------------------------------------------------------------------------
`default_nettype none

// Each input beat is one IMU sample; each produces exactly one result beat.
// A sample is stepped through the RUN state and then the DONE state before
// its result is offered, and a new sample is taken only once the previous
// one is committed: a single 36 x 33 bit signed multiplier is run through
// eleven products (position, heading, the two angle-to-phase conversions,
// the four tilt compensation terms and the two velocity increments), each
// product being registered before it is accumulated. The block does not
// take a new sample while one is in progress; it does accept one while the
// previous result still waits in the output register, and that sample then
// waits before committing until the output register is free. The sine table
// is a constant quarter wave of 2^SINE_TABLE_BITS + 1 entries, read into
// registers. The two configuration registers sit on an APB port at byte
// offsets 0 and 4 and should only be written while the block is idle.
module imu_dead_reckoning_odometry #(
    parameter int SINE_TABLE_BITS = imudr_pkg::SINE_TABLE_BITS_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire imudr_pkg::imu_sample_t in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output imudr_pkg::odom_result_t     out_data,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int TB = SINE_TABLE_BITS;
    localparam int TURN_BITS = TB + 2;
    localparam int QUARTER = 1 << TB;
    localparam int PHASE_SHIFT = 43 - TB;
    localparam int PW = 69;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    // Constant quarter-wave sine table.
    logic [16:0] sine_rom [QUARTER + 1];
    for (genvar gi = 0; gi <= QUARTER; gi++)
    begin : g_rom
        localparam logic [16:0] ENTRY = imudr_pkg::sine_entry(TB, gi);
        assign sine_rom[gi] = ENTRY;
    end

    state_t state_reg;
    logic [3:0] step_reg;

    logic [14:0] threshold_reg;
    logic [31:0] timeout_reg;

    logic signed [31:0] xpos_reg, ypos_reg, head_reg, xvel_reg, yvel_reg;
    logic signed [15:0] wz_reg;
    logic [31:0] prev_time_reg, motion_time_reg;
    logic started_reg;

    imudr_pkg::imu_sample_t smp_reg;
    logic [31:0] h_reg;
    logic [TURN_BITS-1:0] pidx_reg, ridx_reg;
    logic signed [17:0] sinp_reg, cosp_reg, sinr_reg, cosr_reg;
    logic signed [35:0] acc_reg, ax_reg, ay_reg;
    logic signed [PW-1:0] prod_reg;

    // Sine lookup over the full turn by quadrant folding of the quarter wave.
    function automatic logic signed [17:0] sine_at(input logic [TURN_BITS-1:0] idx);
        logic [TB:0] r;
        logic [16:0] v;
        r = {1'b0, idx[TB-1:0]};
        if (idx[TB])
            v = sine_rom[(TB+1)'(QUARTER) - r];
        else
            v = sine_rom[r];
        if (idx[TB+1])
            return -$signed({1'b0, v});
        else
            return $signed({1'b0, v});
    endfunction

    // Shared multiplier operand selection.
    logic signed [35:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [32:0] h_op;
    always_comb
    begin
        h_op = $signed({1'b0, h_reg});
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd0:
            begin
                mul_a = 36'(xvel_reg);
                mul_b = h_op;
            end
            4'd1:
            begin
                mul_a = 36'(yvel_reg);
                mul_b = h_op;
            end
            4'd2:
            begin
                mul_a = 36'(wz_reg);
                mul_b = h_op;
            end
            4'd3:
            begin
                mul_a = 36'(smp_reg.pitch_angle);
                mul_b = imudr_pkg::INV_TWO_PI_Q32;
            end
            4'd4:
            begin
                mul_a = -36'(smp_reg.roll_angle);
                mul_b = imudr_pkg::INV_TWO_PI_Q32;
            end
            4'd6:
            begin
                mul_a = 36'(smp_reg.accel_x);
                mul_b = 33'(cosp_reg);
            end
            4'd7:
            begin
                mul_a = 36'(smp_reg.accel_z);
                mul_b = 33'(sinp_reg);
            end
            4'd8:
            begin
                mul_a = 36'(smp_reg.accel_y);
                mul_b = 33'(cosr_reg);
            end
            4'd9:
            begin
                mul_a = 36'(smp_reg.accel_z);
                mul_b = 33'(sinr_reg);
            end
            4'd10:
            begin
                mul_a = ax_reg;
                mul_b = h_op;
            end
            4'd11:
            begin
                mul_a = ay_reg;
                mul_b = h_op;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round to nearest with ties upward, at the shifts the sequence needs.
    logic signed [PW-1:0] rnd16, rnd10, rnd25, rndph;
    assign rnd16 = (prod_reg + (PW'(1) <<< 15)) >>> 16;
    assign rnd10 = (prod_reg + (PW'(1) <<< 9)) >>> 10;
    assign rnd25 = (prod_reg + (PW'(1) <<< 24)) >>> 25;
    assign rndph = (prod_reg + (PW'(1) <<< (PHASE_SHIFT - 1))) >>> PHASE_SHIFT;

    // Final decisions for the sample in hand.
    logic signed [35:0] ax_abs, ay_abs, thr_q;
    logic active;
    logic [31:0] motion_time_new, idle_age;
    logic still;
    always_comb
    begin
        ax_abs = ax_reg[35] ? -ax_reg : ax_reg;
        ay_abs = ay_reg[35] ? -ay_reg : ay_reg;
        thr_q = $signed(36'({threshold_reg, 15'd0}));
        active = (ax_abs > thr_q) || (ay_abs > thr_q) ||
                 ((wz_reg[15] ? -17'(wz_reg) : 17'(wz_reg)) > $signed({2'b00, threshold_reg}));
        motion_time_new = active ? smp_reg.sample_time : motion_time_reg;
        idle_age = smp_reg.sample_time - motion_time_new;
        still = idle_age > timeout_reg;
    end

    logic accept_in;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept_in = in_valid && in_ready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[2])
            imudr_pkg::REG_THRESHOLD: prdata = {17'd0, threshold_reg};
            imudr_pkg::REG_TIMEOUT:   prdata = timeout_reg;
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            threshold_reg   <= imudr_pkg::THRESHOLD_RESET;
            timeout_reg     <= imudr_pkg::TIMEOUT_RESET;
            xpos_reg        <= '0;
            ypos_reg        <= '0;
            head_reg        <= '0;
            xvel_reg        <= '0;
            yvel_reg        <= '0;
            wz_reg          <= '0;
            prev_time_reg   <= '0;
            motion_time_reg <= '0;
            started_reg     <= 1'b0;
            smp_reg         <= '0;
            h_reg           <= '0;
            pidx_reg        <= '0;
            ridx_reg        <= '0;
            sinp_reg        <= '0;
            cosp_reg        <= '0;
            sinr_reg        <= '0;
            cosr_reg        <= '0;
            acc_reg         <= '0;
            ax_reg          <= '0;
            ay_reg          <= '0;
            prod_reg        <= '0;
            out_valid       <= 1'b0;
            out_data        <= '0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == imudr_pkg::REG_TIMEOUT)
                    timeout_reg <= pwdata;
                else
                    threshold_reg <= pwdata[14:0];
            end

            if (out_valid && out_ready)
                out_valid <= 1'b0;

            prod_reg <= mul_a * mul_b;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept_in)
                    begin
                        smp_reg  <= in_data;
                        step_reg <= '0;
                        state_reg <= ST_RUN;
                        if (started_reg)
                            h_reg <= in_data.sample_time - prev_time_reg;
                        else
                        begin
                            h_reg <= '0;
                            motion_time_reg <= in_data.sample_time;
                        end
                    end
                end
                ST_RUN:
                begin
                    step_reg <= step_reg + 4'd1;
                    case (step_reg)
                        4'd1: xpos_reg <= imudr_pkg::sat_add(xpos_reg, rnd16);
                        4'd2: ypos_reg <= imudr_pkg::sat_add(ypos_reg, rnd16);
                        4'd3: head_reg <= imudr_pkg::sat_add(head_reg, rnd10);
                        4'd4: pidx_reg <= rndph[TURN_BITS-1:0];
                        4'd5:
                        begin
                            ridx_reg <= rndph[TURN_BITS-1:0];
                            sinp_reg <= sine_at(pidx_reg);
                            cosp_reg <= sine_at(pidx_reg + TURN_BITS'(QUARTER));
                        end
                        4'd6:
                        begin
                            sinr_reg <= sine_at(ridx_reg);
                            cosr_reg <= sine_at(ridx_reg + TURN_BITS'(QUARTER));
                        end
                        4'd7: acc_reg <= prod_reg[35:0];
                        4'd8: ax_reg <= acc_reg + prod_reg[35:0];
                        4'd9: acc_reg <= prod_reg[35:0];
                        4'd10:
                        begin
                            ay_reg <= acc_reg + prod_reg[35:0];
                            wz_reg <= smp_reg.yaw_rate;
                        end
                        4'd11: xvel_reg <= imudr_pkg::sat_add(xvel_reg, rnd25);
                        4'd12:
                        begin
                            yvel_reg  <= imudr_pkg::sat_add(yvel_reg, rnd25);
                            state_reg <= ST_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_DONE:
                begin
                    // Wait for the output register to drain before committing.
                    if (!out_valid || out_ready)
                    begin
                        motion_time_reg <= motion_time_new;
                        prev_time_reg   <= smp_reg.sample_time;
                        started_reg     <= 1'b1;
                        if (still)
                        begin
                            xvel_reg <= '0;
                            yvel_reg <= '0;
                            wz_reg   <= '0;
                        end
                        out_valid <= 1'b1;
                        out_data.pos_x      <= xpos_reg;
                        out_data.pos_y      <= ypos_reg;
                        out_data.heading    <= head_reg;
                        out_data.vel_x      <= still ? '0 : xvel_reg;
                        out_data.vel_y      <= still ? '0 : yvel_reg;
                        out_data.turn_rate  <= still ? '0 : wz_reg;
                        out_data.stationary <= still;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // A sample in progress blocks the input until its result is committed.
    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> !in_ready)
        else $error("input taken while a sample is in progress");

    // A stationary result carries cleared velocities and yaw rate.
    a_still_cleared : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.stationary) |->
        (out_data.vel_x == 0 && out_data.vel_y == 0 && out_data.turn_rate == 0))
        else $error("stationary result with non-zero velocity");

    // The sequencer only runs while the input is closed.
    a_run_closed : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !in_ready)
        else $error("input open during sequencing");

endmodule

`default_nettype wire
